// ===== hw/rtl/poev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poev_pkg: shared types, codes and tables for the pulse voice
// Holds the command and register codes, the event struct and the
// elaboration-time builders of the note step ROM and the duty threshold table.
// ----------------------------------------------------------------------------
package poev_pkg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2,
        CMD_CTRL     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_ATTACK    = 2'd0,
        REG_RELEASE   = 2'd1,
        REG_AMPLITUDE = 2'd2
    } reg_idx_t;

    localparam logic [6:0]  CC_EXPRESSION   = 7'd11;
    localparam logic [6:0]  EXPR_RESET      = 7'd64;
    localparam logic [14:0] ATTACK_RESET    = 15'd409;
    localparam logic [14:0] RELEASE_RESET   = 15'd25;
    localparam logic [14:0] AMPLITUDE_RESET = 15'd16000;
    localparam logic [14:0] LEVEL_SCALE     = 15'd258;

    typedef struct packed {
        logic       tick;
        logic       note_on;
        logic       note_off;
        logic       cc_expr;
        logic [6:0] key;
        logic [6:0] value;
    } evt_t;

    typedef logic [31:0] word_table_t [128];

    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] b0;
        logic [63:0] b1;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
        logic [63:0] mid;
        logic [63:0] lo;
        logic [63:0] hi;
        a0  = {32'd0, a[31:0]};
        a1  = {32'd0, a[63:32]};
        b0  = {32'd0, b[31:0]};
        b1  = {32'd0, b[63:32]};
        p00 = a0 * b0;
        p01 = a0 * b1;
        p10 = a1 * b0;
        p11 = a1 * b1;
        mid = {32'd0, p00[63:32]} + {32'd0, p01[31:0]} + {32'd0, p10[31:0]};
        lo  = {mid[31:0], p00[31:0]};
        hi  = p11 + {32'd0, p01[63:32]} + {32'd0, p10[63:32]} + {32'd0, mid[63:32]};
        return (hi << 4) | (lo >> 60);
    endfunction

    function automatic logic [63:0] q60_pow12(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] x6;
        x2 = q60_mul(x, x);
        x3 = q60_mul(x2, x);
        x6 = q60_mul(x3, x3);
        return q60_mul(x6, x6);
    endfunction

    function automatic word_table_t build_step_rom();
        word_table_t rom;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] num;
        logic [63:0] semis [12];
        int          d;
        int          oct;
        lo = 64'd1 << 60;
        hi = (64'd1 << 60) + (64'd1 << 56);
        for (int it = 0; it < 64; it++)
        begin
            if (hi - lo > 64'd1)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (q60_pow12(mid) <= (64'd2 << 60))
                    lo = mid;
                else
                    hi = mid;
            end
        end
        semis[0] = 64'd1 << 60;
        for (int i = 1; i < 12; i++)
            semis[i] = q60_mul(semis[i - 1], lo);
        for (int i = 0; i < 128; i++)
        begin
            d      = i + 3;
            oct    = d / 12;
            num    = (semis[d % 12] >> 2) * 64'd11;
            rom[i] = 32'((num >> (32 - oct)) / 64'd400);
        end
        return rom;
    endfunction

    function automatic word_table_t build_thresh_table();
        word_table_t tbl;
        logic [63:0] duty;
        for (int e = 0; e < 128; e++)
        begin
            duty   = 64'd100 + (64'(e) * 64'd800) / 64'd127;
            tbl[e] = 32'((duty * 64'd4294967295) / 64'd1000);
        end
        return tbl;
    endfunction

endpackage

// ===== hw/rtl/poev_osc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poev_osc: phase accumulator and pulse comparator
// Keeps the phase step, phase and duty threshold; flags the positive half
// of the pulse for the phase after the current tick.
// ----------------------------------------------------------------------------
module poev_osc #(
    parameter int PHASE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  poev_pkg::evt_t    evt,
    output logic              pulse_pos
);

    localparam poev_pkg::word_table_t STEP_ROM     = poev_pkg::build_step_rom();
    localparam poev_pkg::word_table_t THRESH_TABLE = poev_pkg::build_thresh_table();
    localparam logic [31:0]           THRESH_INIT  = THRESH_TABLE[poev_pkg::EXPR_RESET];

    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] thresh_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [31:0]           rom_word;
    logic [31:0]           thresh_word;

    assign rom_word    = STEP_ROM[evt.key];
    assign thresh_word = THRESH_TABLE[evt.value];
    assign phase_next  = phase_reg + step_reg;
    assign pulse_pos   = (phase_next < thresh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            phase_reg  <= '0;
            thresh_reg <= THRESH_INIT[31 -: PHASE_BITS];
        end
        else
        begin
            if (evt.note_on)
                step_reg <= rom_word[31 -: PHASE_BITS];
            if (evt.tick)
                phase_reg <= phase_next;
            if (evt.cc_expr)
                thresh_reg <= thresh_word[31 -: PHASE_BITS];
        end
    end

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !evt.tick |=> $stable(phase_reg))
        else $error("phase moved without a tick");

endmodule

// ===== hw/rtl/poev_env.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poev_env: note gate and linear envelope
// Tracks the active note and its level, and ramps the envelope toward the
// level while gated and toward zero otherwise.
// ----------------------------------------------------------------------------
module poev_env (
    input  logic           clk,
    input  logic           rst_n,
    input  poev_pkg::evt_t evt,
    input  logic [14:0]    attack_step,
    input  logic [14:0]    release_step,
    output logic [14:0]    env_next
);

    logic        gate_reg;
    logic        note_valid_reg;
    logic [6:0]  note_reg;
    logic [14:0] level_reg;
    logic [14:0] env_reg;
    logic [14:0] level_new;
    logic [14:0] target;
    logic [15:0] env_up;
    logic [15:0] env_floor;

    assign level_new = 15'({8'd0, evt.value} * poev_pkg::LEVEL_SCALE)
                     + 15'(evt.value == 7'd127);
    assign target    = gate_reg ? level_reg : '0;
    assign env_up    = {1'b0, env_reg} + {1'b0, attack_step};
    assign env_floor = {1'b0, target} + {1'b0, release_step};

    always_comb
    begin
        if (env_reg < target)
            env_next = (env_up > {1'b0, target}) ? target : env_up[14:0];
        else if (env_reg > target)
            env_next = ({1'b0, env_reg} < env_floor) ? target : (env_reg - release_step);
        else
            env_next = env_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg       <= 1'b0;
            note_valid_reg <= 1'b0;
            note_reg       <= '0;
            level_reg      <= '0;
            env_reg        <= '0;
        end
        else
        begin
            if (evt.note_on)
            begin
                gate_reg       <= 1'b1;
                note_valid_reg <= 1'b1;
                note_reg       <= evt.key;
                level_reg      <= level_new;
            end
            else if (evt.note_off && note_valid_reg && (note_reg == evt.key))
                gate_reg <= 1'b0;
            if (evt.tick)
                env_reg <= env_next;
        end
    end

    a_env_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.tick && !gate_reg && (env_reg == '0)) |=> (env_reg == '0))
        else $error("envelope rose while gated off");

endmodule

// ===== hw/rtl/pulse_oscillator_envelope_voice.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_oscillator_envelope_voice: monophonic pulse synth voice
// A tick request passes the input register, then the sample register, and
// waits while the output stalls; otherwise 1 request per cycle is taken,
// events and ticks back to back, as set by the single update pass between
// input and sample register (envelope step, then the 15x15 amplitude product).
// Reset: asynchronous, clears phase, envelope, gate and note state, loads
// the register defaults and expression 64; no clearing pass.
// ----------------------------------------------------------------------------
module pulse_oscillator_envelope_voice #(
    parameter int PHASE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [6:0]         key,
    input  logic [6:0]         value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    logic                s1_valid_reg;
    poev_pkg::cmd_t      s1_cmd_reg;
    logic [6:0]          s1_key_reg;
    logic [6:0]          s1_value_reg;
    logic                out_valid_reg;
    logic signed [15:0]  sample_reg;
    logic signed [15:0]  sample_next;
    logic [14:0]         attack_reg;
    logic [14:0]         release_reg;
    logic [14:0]         amp_reg;
    logic                out_free;
    logic                advance;
    logic                accept;
    logic                pulse_pos;
    logic [14:0]         env_next;
    logic [29:0]         prod;
    logic signed [30:0]  neg_prod;
    poev_pkg::evt_t      evt;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && ((s1_cmd_reg != poev_pkg::CMD_TICK) || out_free);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        evt       = '0;
        evt.key   = s1_key_reg;
        evt.value = s1_value_reg;
        if (advance)
        begin
            unique case (s1_cmd_reg)
                poev_pkg::CMD_TICK:     evt.tick = 1'b1;
                poev_pkg::CMD_NOTE_ON:  evt.note_on = 1'b1;
                poev_pkg::CMD_NOTE_OFF: evt.note_off = 1'b1;
                poev_pkg::CMD_CTRL:     evt.cc_expr = (s1_key_reg == poev_pkg::CC_EXPRESSION);
                default:                evt.tick = 1'b0;
            endcase
        end
    end

    poev_osc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_osc (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .pulse_pos (pulse_pos)
    );

    poev_env u_env (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .attack_step  (attack_reg),
        .release_step (release_reg),
        .env_next     (env_next)
    );

    assign prod     = {15'd0, amp_reg} * {15'd0, env_next};
    assign neg_prod = -$signed({1'b0, prod});

    always_comb
    begin
        if (pulse_pos)
            sample_next = $signed(16'(prod >> 15));
        else
            sample_next = 16'(neg_prod >>> 15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= poev_pkg::ATTACK_RESET;
            release_reg <= poev_pkg::RELEASE_RESET;
            amp_reg     <= poev_pkg::AMPLITUDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                poev_pkg::REG_ATTACK:    attack_reg <= cfg_data;
                poev_pkg::REG_RELEASE:   release_reg <= cfg_data;
                poev_pkg::REG_AMPLITUDE: amp_reg <= cfg_data;
                default:                 amp_reg <= amp_reg;
            endcase
        end
    end

    // hold the request until the stage can pass it on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= poev_pkg::cmd_t'(cmd);
            s1_key_reg   <= key;
            s1_value_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (evt.tick)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (evt.tick)
            sample_reg <= sample_next;
    end

    a_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
        evt.tick |=> out_valid_reg)
        else $error("tick without a sample");

    a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("stall with an empty input stage");

    a_event_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_cmd_reg != poev_pkg::CMD_TICK)) |-> advance)
        else $error("event request blocked");

endmodule

// ===== bench/pulse_oscillator_envelope_voice_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_oscillator_envelope_voice_test: self-checking bench for the pulse voice
// Drives a short table of directed requests, then random request streams
// under several register settings, with random gaps on the request side and
// random stalls on the sample side. A local model of the voice (note step
// table, phase accumulator, duty threshold, linear envelope) predicts every
// sample; samples are checked in order against it or a row's known value.
// ----------------------------------------------------------------------------
module pulse_oscillator_envelope_voice_test;

    typedef struct {
        poev_pkg::cmd_t op;
        logic [6:0]     k;
        logic [6:0]     v;
        bit             known;
        logic [15:0]    want;
    } tone_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    poev_pkg::cmd_t     cmd;
    logic [6:0]         key;
    logic [6:0]         value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] sample;
    logic               cfg_valid;
    logic               cfg_ready;
    poev_pkg::reg_idx_t cfg_index;
    logic [14:0]        cfg_data;

    logic [31:0] note_step [128];
    logic [15:0] expected_samples [$];

    logic [14:0] v_attack;
    logic [14:0] v_release;
    logic [14:0] v_amp;
    logic [31:0] v_phase;
    logic [31:0] v_env;
    logic [31:0] v_step;
    bit          v_gate;
    logic [6:0]  v_vel;
    logic [6:0]  v_expr;
    logic [6:0]  v_note;
    bit          v_note_valid;

    bit quiet;
    int sink_hold;
    int errors;

    tone_row_t directed_rows [24] = '{
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b1, 16'd0},
        '{poev_pkg::CMD_NOTE_OFF, 7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b1, 16'd0},
        '{poev_pkg::CMD_NOTE_ON,  7'd60,  7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b1, 16'd0},
        '{poev_pkg::CMD_NOTE_ON,  7'd127, 7'd127, 1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd127, 7'd127, 1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_CTRL,     7'd11,  7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_CTRL,     7'd11,  7'd127, 1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_CTRL,     7'd10,  7'd5,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_NOTE_OFF, 7'd126, 7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_NOTE_OFF, 7'd127, 7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_NOTE_ON,  7'd0,   7'd1,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_NOTE_ON,  7'd69,  7'd64,  1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0},
        '{poev_pkg::CMD_TICK,     7'd0,   7'd0,   1'b0, 16'd0}
    };

    poev_pkg::reg_idx_t reg_order [3] = '{poev_pkg::REG_ATTACK, poev_pkg::REG_RELEASE,
                                          poev_pkg::REG_AMPLITUDE};

    pulse_oscillator_envelope_voice u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] fx_pow12(logic [63:0] x);
        logic [63:0] x3;
        logic [63:0] x6;
        x3 = fx_mul(fx_mul(x, x), x);
        x6 = fx_mul(x3, x3);
        return fx_mul(x6, x6);
    endfunction

    task automatic fill_note_steps();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] semitone [12];
        lo = 64'd1 << 60;
        hi = lo + (64'd1 << 56);
        while (hi - lo > 64'd1)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (fx_pow12(mid) <= (64'd2 << 60))
                lo = mid;
            else
                hi = mid;
        end
        semitone[0] = 64'd1 << 60;
        for (int i = 1; i < 12; i++)
            semitone[i] = fx_mul(semitone[i - 1], lo);
        for (int n = 0; n < 128; n++)
        begin
            num = (semitone[(n + 3) % 12] >> 2) * 64'd11;
            den = 64'd400 << (32 - (n + 3) / 12);
            note_step[n] = 32'(num / den);
        end
    endtask

    task automatic reset_voice_model();
        v_attack     = poev_pkg::ATTACK_RESET;
        v_release    = poev_pkg::RELEASE_RESET;
        v_amp        = poev_pkg::AMPLITUDE_RESET;
        v_phase      = '0;
        v_env        = '0;
        v_step       = '0;
        v_gate       = 1'b0;
        v_vel        = '0;
        v_expr       = poev_pkg::EXPR_RESET;
        v_note       = '0;
        v_note_valid = 1'b0;
    endtask

    // Advance the voice by one request; return 1 with the sample on a tick.
    function automatic bit predict_voice(poev_pkg::cmd_t op, logic [6:0] k, logic [6:0] v,
                                         output logic [15:0] s);
        logic [63:0] duty;
        logic [31:0] thresh;
        logic [31:0] target;
        logic [31:0] prod;
        logic [31:0] res;
        s = '0;
        case (op)
            poev_pkg::CMD_NOTE_ON:
            begin
                v_step       = note_step[k];
                v_gate       = 1'b1;
                v_vel        = v;
                v_note       = k;
                v_note_valid = 1'b1;
                return 1'b0;
            end
            poev_pkg::CMD_NOTE_OFF:
            begin
                if (v_note_valid && v_note == k)
                    v_gate = 1'b0;
                return 1'b0;
            end
            poev_pkg::CMD_CTRL:
            begin
                if (k == poev_pkg::CC_EXPRESSION)
                    v_expr = v;
                return 1'b0;
            end
            default: ;
        endcase
        v_phase = v_phase + v_step;
        duty    = 64'd100 + (64'(v_expr) * 64'd800) / 64'd127;
        thresh  = 32'((duty * 64'hFFFF_FFFF) / 64'd1000);
        target  = v_gate ? (32'(v_vel) * 32'd32767) / 32'd127 : 32'd0;
        if (v_env < target)
        begin
            v_env = v_env + 32'(v_attack);
            if (v_env > target)
                v_env = target;
        end
        else if (v_env > target)
        begin
            if (v_env < target + 32'(v_release))
                v_env = target;
            else
                v_env = v_env - 32'(v_release);
        end
        prod = 32'(v_amp) * v_env;
        if (v_phase < thresh)
            res = prod >> 15;
        else
            res = 32'd0 - ((prod + 32'd32767) >> 15);
        s = res[15:0];
        return 1'b1;
    endfunction

    task automatic flag_error(string what, logic [15:0] want, logic [15:0] got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected %0d, got %0d", $time, what,
                     $signed(want), $signed(got));
    endtask

    // Entered and left at a falling edge.
    task automatic send_request(poev_pkg::cmd_t op, logic [6:0] k, logic [6:0] v,
                                bit known, logic [15:0] want);
        int          gap;
        logic [15:0] s;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_voice(op, k, v, s))
            expected_samples.push_back(known ? want : s);
        @(negedge clk);
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_voice_regs(logic [14:0] atk, logic [14:0] rel, logic [14:0] amp);
        logic [14:0] vals [3];
        vals[0] = atk;
        vals[1] = rel;
        vals[2] = amp;
        drain_requests();
        cfg_valid <= 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            cfg_index <= reg_order[r];
            cfg_data  <= vals[r];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (reg_order[r])
                poev_pkg::REG_ATTACK:  v_attack  = vals[r];
                poev_pkg::REG_RELEASE: v_release = vals[r];
                default:               v_amp     = vals[r];
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_stream(int count);
        int             left;
        int             pick;
        poev_pkg::cmd_t op;
        logic [6:0]     k;
        logic [6:0]     v;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            k    = 7'($urandom_range(0, 127));
            v    = 7'($urandom_range(0, 127));
            if (pick < 70)
                op = poev_pkg::CMD_TICK;
            else if (pick < 80)
                op = poev_pkg::CMD_NOTE_ON;
            else if (pick < 90)
            begin
                op = poev_pkg::CMD_NOTE_OFF;
                if ($urandom_range(0, 1) == 1)
                    k = v_note;
            end
            else
            begin
                op = poev_pkg::CMD_CTRL;
                if ($urandom_range(0, 1) == 1)
                    k = poev_pkg::CC_EXPRESSION;
            end
            send_request(op, k, v, 1'b0, 16'd0);
            left--;
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_samples.size() == 0)
                flag_error("unexpected sample", 16'd0, sample);
            else if (sample !== expected_samples[0])
                flag_error("sample mismatch", expected_samples[0], sample);
            if (expected_samples.size() != 0)
                void'(expected_samples.pop_front());
            sink_hold = quiet ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            out_stall <= 1'b1;
            sink_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        logic [14:0] atk;
        logic [14:0] rel;
        logic [14:0] amp;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = poev_pkg::CMD_TICK;
        key       = '0;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_index = poev_pkg::REG_ATTACK;
        cfg_data  = '0;
        quiet     = 1'b0;
        sink_hold = 0;
        errors    = 0;
        fill_note_steps();
        reset_voice_model();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].k, directed_rows[i].v,
                         directed_rows[i].known, directed_rows[i].want);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    atk = 15'd32767;
                    rel = 15'd32767;
                    amp = 15'd32767;
                end
                1:
                begin
                    atk = 15'd1;
                    rel = 15'd1;
                    amp = 15'd0;
                end
                2:
                begin
                    atk = 15'd32767;
                    rel = 15'd1;
                    amp = 15'd32767;
                end
                3:
                begin
                    atk = 15'd1;
                    rel = 15'd32767;
                    amp = 15'd10922;
                end
                default:
                begin
                    atk = 15'($urandom_range(1, 32767));
                    rel = 15'($urandom_range(1, 32767));
                    amp = 15'($urandom_range(0, 32767));
                end
            endcase
            write_voice_regs(atk, rel, amp);
            quiet = (ph == 2 || ph == 6);
            run_random_stream(128);
        end

        quiet = 1'b0;
        drain_requests();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
